### rtl/pclt_pkg.sv
// ----------------------------------------------------------------------------
// pclt_pkg: shared types and constants of the pair contact list table
// Field widths, request codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package pclt_pkg;

	localparam int unsigned REQ_W  = 2;
	localparam int unsigned PART_W = 10;
	localparam int unsigned LEN_W  = 5;
	localparam int unsigned COLL_W = 32;

	localparam int unsigned NUM_PARTICLES_DEF = 1024;
	localparam int unsigned LIST_SLOTS_DEF    = 16;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD    = 2'd0,
		REQ_QUERY  = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef struct packed {
		logic clr_wr;
		logic load_req;
		logic rd_b;
		logic cap_a;
		logic add_a;
		logic add_b;
		logic scan_step;
		logic del_rd;
		logic del_wr;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic ok;
		req_t req;
		logic hit;
		logic scan_done;
	} sts_t;

endpackage

### rtl/pclt_ram.sv
// ----------------------------------------------------------------------------
// pclt_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pclt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/pclt_dp.sv
// ----------------------------------------------------------------------------
// pclt_dp: datapath of the pair contact list table
// Request registers, fill/counter/contact memories, list scan and the
// output word register.
// ----------------------------------------------------------------------------
module pclt_dp #(
	parameter int unsigned NUM_PARTICLES = pclt_pkg::NUM_PARTICLES_DEF,
	parameter int unsigned LIST_SLOTS    = pclt_pkg::LIST_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pclt_pkg::cmd_t                cmd,
	output pclt_pkg::sts_t                sts,
	input  logic [pclt_pkg::REQ_W-1:0]    req_type,
	input  logic [pclt_pkg::PART_W-1:0]   part_a,
	input  logic [pclt_pkg::PART_W-1:0]   part_b,
	output logic                          found,
	output logic [pclt_pkg::LEN_W-1:0]    list_len_a,
	output logic [pclt_pkg::COLL_W-1:0]   coll_count_a,
	output logic                          list_cleared
);

	import pclt_pkg::*;

	localparam int unsigned AW     = $clog2(NUM_PARTICLES);
	localparam int unsigned SW     = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;
	localparam int unsigned CW     = $clog2(LIST_SLOTS + 1);
	localparam int unsigned SDEPTH = NUM_PARTICLES * (2 ** SW);

	function automatic logic [LEN_W-1:0] to_len(input logic [CW-1:0] n);
		logic [31:0] w;
		w = 32'(n);
		return w[LEN_W-1:0];
	endfunction

	function automatic logic [SW-1:0] to_slot(input logic [CW-1:0] n);
		logic [31:0] w;
		w = 32'(n);
		return w[SW-1:0];
	endfunction

	// request registers
	req_t              req_q;
	logic [PART_W-1:0] pa_q;
	logic [PART_W-1:0] pb_q;
	logic              ok_q;
	logic [CW-1:0]     n_a_q;

	// result being built
	logic [LEN_W-1:0]  res_len_q;
	logic [COLL_W-1:0] res_coll_q;
	logic              res_found_q;
	logic              res_clr_q;

	// scan
	logic [CW-1:0]     rd_i_q;
	logic              cmp_v_q;
	logic [SW-1:0]     cmp_slot_q;
	logic [SW-1:0]     del_slot_q;

	logic [AW-1:0]     clr_idx_q;

	// output word
	logic              found_q;
	logic [LEN_W-1:0]  len_q;
	logic [COLL_W-1:0] coll_q;
	logic              cleared_q;

	logic [31:0]       a_w, b_w, in_a_w, in_b_w;
	logic [AW-1:0]     a_addr, b_addr;
	logic              a_ok, b_ok;

	logic [CW-1:0]     fill_rdata, fill_wdata, n_inc, last;
	logic [COLL_W-1:0] coll_rdata, coll_wdata, coll_inc;
	logic [PART_W-1:0] store_rdata, store_wdata;
	logic              full;
	logic              hit;

	logic              fill_we, coll_we, store_we;
	logic [AW-1:0]     fill_waddr, coll_waddr, fill_raddr;
	logic [AW+SW-1:0]  store_waddr, store_raddr;

	assign a_w    = 32'(pa_q);
	assign b_w    = 32'(pb_q);
	assign a_addr = a_w[AW-1:0];
	assign b_addr = b_w[AW-1:0];
	assign in_a_w = 32'(part_a);
	assign in_b_w = 32'(part_b);
	assign a_ok   = in_a_w < 32'(NUM_PARTICLES);
	assign b_ok   = in_b_w < 32'(NUM_PARTICLES);

	assign full     = fill_rdata >= CW'(LIST_SLOTS);
	assign n_inc    = fill_rdata + CW'(1);
	assign coll_inc = (coll_rdata == '1) ? coll_rdata : coll_rdata + COLL_W'(1);
	assign last     = n_a_q - CW'(1);
	assign hit      = cmp_v_q && (store_rdata == pb_q);

	assign fill_raddr  = cmd.rd_b ? b_addr : a_addr;
	assign store_raddr = cmd.del_rd ? {a_addr, to_slot(last)} : {a_addr, to_slot(rd_i_q)};

	always_comb begin
		fill_we     = 1'b0;
		fill_waddr  = a_addr;
		fill_wdata  = '0;
		coll_we     = 1'b0;
		coll_waddr  = a_addr;
		coll_wdata  = coll_inc;
		store_we    = 1'b0;
		store_waddr = {a_addr, to_slot(fill_rdata)};
		store_wdata = pb_q;
		if (cmd.clr_wr) begin
			fill_we    = 1'b1;
			fill_waddr = clr_idx_q;
			coll_we    = 1'b1;
			coll_waddr = clr_idx_q;
			coll_wdata = '0;
		end else if (cmd.add_a) begin
			fill_we    = 1'b1;
			fill_wdata = full ? '0 : n_inc;
			coll_we    = 1'b1;
			store_we   = !full;
		end else if (cmd.add_b) begin
			fill_we     = 1'b1;
			fill_waddr  = b_addr;
			fill_wdata  = full ? '0 : n_inc;
			coll_we     = 1'b1;
			coll_waddr  = b_addr;
			store_we    = !full;
			store_waddr = {b_addr, to_slot(fill_rdata)};
			store_wdata = pa_q;
		end else if (cmd.del_wr) begin
			fill_we     = 1'b1;
			fill_wdata  = last;
			store_we    = 1'b1;
			store_waddr = {a_addr, del_slot_q};
			store_wdata = store_rdata;
		end
	end

	pclt_ram #(.WIDTH(CW), .DEPTH(NUM_PARTICLES)) u_fill (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.raddr (fill_raddr),
		.rdata (fill_rdata)
	);

	pclt_ram #(.WIDTH(COLL_W), .DEPTH(NUM_PARTICLES)) u_coll (
		.clk   (clk),
		.we    (coll_we),
		.waddr (coll_waddr),
		.wdata (coll_wdata),
		.raddr (fill_raddr),
		.rdata (coll_rdata)
	);

	pclt_ram #(.WIDTH(PART_W), .DEPTH(SDEPTH)) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_waddr),
		.wdata (store_wdata),
		.raddr (store_raddr),
		.rdata (store_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			cmp_v_q   <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_idx_q <= clr_idx_q + AW'(1);
			end
			if (cmd.cap_a) begin
				cmp_v_q <= 1'b0;
			end else if (cmd.scan_step) begin
				cmp_v_q <= rd_i_q < n_a_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req_t'(req_type);
			pa_q  <= part_a;
			pb_q  <= part_b;
			ok_q  <= a_ok && (b_ok || (req_t'(req_type) != REQ_ADD));
		end
		if (cmd.scan_step && hit) begin
			res_found_q <= 1'b1;
			del_slot_q  <= cmp_slot_q;
		end
		if (cmd.scan_step && (rd_i_q < n_a_q)) begin
			rd_i_q     <= rd_i_q + CW'(1);
			cmp_slot_q <= to_slot(rd_i_q);
		end
		if (cmd.cap_a) begin
			n_a_q       <= fill_rdata;
			rd_i_q      <= '0;
			res_found_q <= 1'b0;
			if (cmd.add_a) begin
				res_len_q  <= to_len(full ? '0 : n_inc);
				res_coll_q <= coll_inc;
				res_clr_q  <= full;
			end else if (ok_q) begin
				res_len_q  <= to_len(fill_rdata);
				res_coll_q <= coll_rdata;
				res_clr_q  <= 1'b0;
			end else begin
				res_len_q  <= '0;
				res_coll_q <= '0;
				res_clr_q  <= 1'b0;
			end
		end
		// self contact: a's list is b's list
		if (cmd.add_b && (pa_q == pb_q)) begin
			res_len_q  <= to_len(full ? '0 : n_inc);
			res_coll_q <= coll_inc;
			res_clr_q  <= res_clr_q | full;
		end
		if (cmd.del_wr) begin
			res_len_q <= to_len(last);
		end
		if (cmd.load_out) begin
			found_q   <= res_found_q;
			len_q     <= res_len_q;
			coll_q    <= res_coll_q;
			cleared_q <= res_clr_q;
		end
	end

	assign sts.clr_last  = clr_idx_q == AW'(NUM_PARTICLES - 1);
	assign sts.ok        = ok_q;
	assign sts.req       = req_q;
	assign sts.hit       = hit;
	assign sts.scan_done = !hit && (rd_i_q >= n_a_q);

	assign found        = found_q;
	assign list_len_a   = len_q;
	assign coll_count_a = coll_q;
	assign list_cleared = cleared_q;

endmodule

### rtl/pclt_ctrl.sv
// ----------------------------------------------------------------------------
// pclt_ctrl: controller of the pair contact list table
// Sequences the clearing pass, add, scan, delete and the output handshake.
// ----------------------------------------------------------------------------
module pclt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  pclt_pkg::sts_t sts,
	output pclt_pkg::cmd_t cmd
);

	import pclt_pkg::*;

	typedef enum logic [9:0] {
		S_CLEAR = 10'b00_0000_0001,
		S_IDLE  = 10'b00_0000_0010,
		S_RDA   = 10'b00_0000_0100,
		S_GOTA  = 10'b00_0000_1000,
		S_RDB   = 10'b00_0001_0000,
		S_ADDB  = 10'b00_0010_0000,
		S_SCAN  = 10'b00_0100_0000,
		S_DRD   = 10'b00_1000_0000,
		S_DWR   = 10'b01_0000_0000,
		S_DONE  = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		cmd           = '0;
		state_d       = state_q;
		cmd.load_out  = (state_q == S_DONE) && (!out_valid_q || out_ready);
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_RDA;
				end
			end
			S_RDA: begin
				state_d = S_GOTA;
			end
			S_GOTA: begin
				cmd.cap_a = 1'b1;
				if (!sts.ok) begin
					state_d = S_DONE;
				end else begin
					case (sts.req)
						REQ_ADD: begin
							cmd.add_a = 1'b1;
							state_d   = S_RDB;
						end
						REQ_QUERY, REQ_DELETE: begin
							state_d = S_SCAN;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_RDB: begin
				cmd.rd_b = 1'b1;
				state_d  = S_ADDB;
			end
			S_ADDB: begin
				cmd.add_b = 1'b1;
				state_d   = S_DONE;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.hit) begin
					state_d = (sts.req == REQ_DELETE) ? S_DRD : S_DONE;
				end else if (sts.scan_done) begin
					state_d = S_DONE;
				end
			end
			S_DRD: begin
				cmd.del_rd = 1'b1;
				state_d    = S_DWR;
			end
			S_DWR: begin
				cmd.del_wr = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (cmd.load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

endmodule

### rtl/pair_contact_list_table_unit.sv
// ----------------------------------------------------------------------------
// pair_contact_list_table_unit: per-particle contact lists with counters
// Top level: controller, datapath and interface checks.
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass over all NUM_PARTICLES entries of
// the fill-count and collision-counter memories, with in_ready low. One
// request is worked at a time; each step is one access of the memories, each
// with one write and one read port. An add reads a, appends to a, reads b and
// appends to b. A query scans a's list up to its fill count and stops early
// when b is found: the scan reads one stored entry per cycle. A delete that
// finds b then moves the last entry of a's list into the freed slot. A
// finished word sits in the output register while the next request is
// accepted and worked.
module pair_contact_list_table_unit #(
	parameter int unsigned NUM_PARTICLES = pclt_pkg::NUM_PARTICLES_DEF,
	parameter int unsigned LIST_SLOTS    = pclt_pkg::LIST_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pclt_pkg::REQ_W-1:0]    req_type,
	input  logic [pclt_pkg::PART_W-1:0]   part_a,
	input  logic [pclt_pkg::PART_W-1:0]   part_b,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic [pclt_pkg::LEN_W-1:0]    list_len_a,
	output logic [pclt_pkg::COLL_W-1:0]   coll_count_a,
	output logic                          list_cleared
);

	import pclt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pclt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pclt_dp #(
		.NUM_PARTICLES (NUM_PARTICLES),
		.LIST_SLOTS    (LIST_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req_type),
		.part_a       (part_a),
		.part_b       (part_b),
		.found        (found),
		.list_len_a   (list_len_a),
		.coll_count_a (coll_count_a),
		.list_cleared (list_cleared)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("accepted a word while a request was in work");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(list_len_a) <= 32'(LIST_SLOTS)))
		else $error("list length beyond slot count");

	a_clear_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && list_cleared) |-> !found)
		else $error("cleared list reported with found");

	a_clear_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && list_cleared) |-> (coll_count_a != '0))
		else $error("cleared list without counted collision");

endmodule
